FILE: rtl/ata_tfab_pkg.sv
`default_nettype none
package ata_tfab_pkg;

  // Slots that may be used; slot indexes at or above this are reported missing.
  localparam int unsigned DRIVE_SLOTS = 4;
  // Slots held in the configuration registers (fixed by the register map).
  localparam int unsigned MAX_SLOTS   = 4;

  // Configuration register indexes
  localparam logic [2:0] REG_SIZE0 = 3'd0;
  localparam logic [2:0] REG_FLAGS = 3'd4;

  // Per-slot flag bit positions
  localparam int unsigned FLG_PRESENT = 0;
  localparam int unsigned FLG_ATAPI   = 1;
  localparam int unsigned FLG_LBA     = 2;
  localparam int unsigned FLG_CHANNEL = 3;
  localparam int unsigned FLG_SLAVE   = 4;

  // ATA opcodes and taskfile constants
  localparam logic [7:0] CMD_RD       = 8'h20;
  localparam logic [7:0] CMD_RD_EXT   = 8'h24;
  localparam logic [7:0] CMD_WR       = 8'h30;
  localparam logic [7:0] CMD_WR_EXT   = 8'h34;
  localparam logic [7:0] CMD_PACKET   = 8'hA0;
  localparam logic [7:0] DEVSEL_CHS   = 8'hA0;
  localparam logic [7:0] DEVSEL_LBA   = 8'hE0;
  localparam logic [7:0] ATAPI_BC_LO  = 8'h00;  // 2048-byte transfer
  localparam logic [7:0] ATAPI_BC_HI  = 8'h08;

  // floor(x / 63) == (x * CHS_RECIP) >> CHS_SHIFT for any 28-bit x
  localparam logic [28:0] CHS_RECIP = 29'd272696337;
  localparam int unsigned CHS_SHIFT = 34;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_DRIVE = 2'd1,
    ST_BAD_POS  = 2'd2,
    ST_WR_PROT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    AM_CHS    = 2'd0,
    AM_LBA28  = 2'd1,
    AM_LBA48  = 2'd2,
    AM_PACKET = 2'd3
  } mode_t;

  typedef logic [4:0] slot_flags_t;

  typedef struct packed {
    logic        op;
    logic [2:0]  drive;
    logic [31:0] lba;
    logic [7:0]  sector_count;
  } req_t;

  typedef struct packed {
    status_t     status;
    mode_t       addr_mode;
    logic        channel;
    logic [7:0]  device_select;
    logic [7:0]  command;
    logic [7:0]  count_byte;
    logic [7:0]  addr_byte0;
    logic [7:0]  addr_byte1;
    logic [7:0]  addr_byte2;
    logic [7:0]  addr_byte3;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/ata_taskfile_address_builder_unit.sv
// ATA taskfile address builder.
// Input channel (in_*): one sector read/write request per item: drive slot, start LBA,
// sector count in in_tdata, read/write op in in_tuser. Output channel (out_*): one
// result item per request: status and address mode in out_tuser, channel, device
// select, opcode, count and four address bytes in out_tdata. Rejected requests carry
// only a status; all taskfile bytes are zero.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the four slot sizes (index 0..3)
// and the packed slot flags (index 4); other indexes are ignored. Write only while
// the block is idle.
// Order: an accepted item is held in the request register, then its result is loaded
// into the result register, which drives out_tvalid. Throughput: one item per
// cycle while out_tready is high; the two-stage register path (request register,
// result register) holds the check, the LBA/CHS split and the byte formatting, and
// the CHS divide-by-63 is a single reciprocal multiply in that path.
// Stall: when out_tready is low, the result register holds; the request register
// still takes one more item, after which in_tready drops until the output drains.
// Reset (rst_n low, synchronous): both stages empty, all configuration registers
// cleared, so every slot reads as not present.
`default_nettype none
module ata_taskfile_address_builder_unit
  import ata_tfab_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  // request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // drive[2:0], lba[34:3], sector_count[42:35], zero fill
  input  wire logic        in_tuser,   // op
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata,  // channel, device_select, command, count_byte,
                                       // addr_byte0..addr_byte3, zero fill
  output logic      [3:0]  out_tuser   // status[1:0], addr_mode[3:2]
);

  // configuration registers
  logic        [MAX_SLOTS-1:0][31:0] size_r;
  slot_flags_t [MAX_SLOTS-1:0]       flags_r;

  // pipeline
  logic    s1_valid_r, s1_valid_nxt;
  req_t    s1_req_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t res;
  logic    adv_out;   // result register may load

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= '0;
      flags_r <= '0;
    end else if (cfg_we) begin
      priority if (cfg_addr == REG_FLAGS) begin
        flags_r <= cfg_wdata[19:0];
      end else if (cfg_addr < REG_FLAGS) begin
        size_r[cfg_addr[1:0]] <= cfg_wdata;
      end else begin
        // unmapped index: ignored
      end
    end
  end

  always_comb begin
    adv_out       = !out_valid_r || out_tready;
    in_tready     = !s1_valid_r || adv_out;
    s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
    out_valid_nxt = adv_out ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r.op           <= in_tuser;
      s1_req_r.drive        <= in_tdata[2:0];
      s1_req_r.lba          <= in_tdata[34:3];
      s1_req_r.sector_count <= in_tdata[42:35];
    end
    if (adv_out && s1_valid_r) begin
      out_res_r <= res;
    end
  end

  ata_tfab_encode u_encode (
    .req   (s1_req_r),
    .size  (size_r),
    .flags (flags_r),
    .res   (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_res_r.addr_mode, out_res_r.status};
  assign out_tdata  = {7'b0,
                       out_res_r.addr_byte3, out_res_r.addr_byte2,
                       out_res_r.addr_byte1, out_res_r.addr_byte0,
                       out_res_r.count_byte, out_res_r.command,
                       out_res_r.device_select, out_res_r.channel};

`ifndef SYNTHESIS
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != ST_OK) |-> (out_tdata == '0))
    else $error("rejected item carries taskfile bytes");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status == ST_OK) |-> (out_res_r.count_byte != 8'd0))
    else $error("accepted item with zero count byte");

  a_packet_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status == ST_OK && out_res_r.addr_mode == AM_PACKET)
      |-> (out_res_r.command == CMD_PACKET))
    else $error("packet mode without packet opcode");

  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv_out) |=> out_valid_r)
    else $error("request stage item lost");
`endif

endmodule
`default_nettype wire

FILE: rtl/ata_tfab_chs.sv
`default_nettype none
// LBA to CHS split for 63 sectors/track, 16 heads. Divide by reciprocal multiply.
module ata_tfab_chs
  import ata_tfab_pkg::*;
(
  input  wire logic [27:0] lba,
  output logic      [5:0]  sector,   // 1..63
  output logic      [3:0]  head,
  output logic      [15:0] cylinder  // truncated to 16 bits
);

  logic [56:0] prod;
  logic [22:0] quot;     // lba / 63
  logic [28:0] quot63;
  logic [27:0] rem;

  always_comb begin
    prod     = 57'(lba) * 57'(CHS_RECIP);
    quot     = prod[56:CHS_SHIFT];
    quot63   = {quot, 6'b0} - 29'(quot);
    rem      = lba - quot63[27:0];
    sector   = rem[5:0] + 6'd1;
    head     = quot[3:0];
    cylinder = quot[19:4];
  end

endmodule
`default_nettype wire

FILE: rtl/ata_tfab_encode.sv
`default_nettype none
// Request check and taskfile byte generation, purely combinational.
module ata_tfab_encode
  import ata_tfab_pkg::*;
(
  input  wire req_t                              req,
  input  wire logic        [MAX_SLOTS-1:0][31:0] size,
  input  wire slot_flags_t [MAX_SLOTS-1:0]       flags,
  output result_t                                res
);

  logic        slot_ok;
  slot_flags_t fl;
  logic [31:0] slot_size;
  logic [32:0] end_lba;
  logic        range_bad;
  logic        atapi;
  logic        slave;
  status_t     status;
  logic [7:0]  count;
  logic [5:0]  chs_sect;
  logic [3:0]  chs_head;
  logic [15:0] chs_cyl;

  ata_tfab_chs u_chs (
    .lba      (req.lba[27:0]),
    .sector   (chs_sect),
    .head     (chs_head),
    .cylinder (chs_cyl)
  );

  always_comb begin
    slot_ok   = (32'(req.drive) < DRIVE_SLOTS);
    fl        = flags[req.drive[1:0]];
    slot_size = size[req.drive[1:0]];
    atapi     = fl[FLG_ATAPI];
    slave     = fl[FLG_SLAVE];
    end_lba   = {1'b0, req.lba} + 33'(req.sector_count);
    range_bad = end_lba > {1'b0, slot_size};
    count     = (req.sector_count == 8'd0) ? 8'd1 : req.sector_count;

    priority if (!slot_ok || !fl[FLG_PRESENT]) begin
      status = ST_NO_DRIVE;
    end else if (!atapi && range_bad) begin
      status = ST_BAD_POS;
    end else if (atapi && req.op == OP_WRITE) begin
      status = ST_WR_PROT;
    end else begin
      status = ST_OK;
    end

    res        = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.channel    = fl[FLG_CHANNEL];
      res.count_byte = count;
      priority if (atapi) begin
        res.addr_mode     = AM_PACKET;
        res.command       = CMD_PACKET;
        res.device_select = {3'b000, slave, 4'h0};
        res.addr_byte1    = ATAPI_BC_LO;
        res.addr_byte2    = ATAPI_BC_HI;
      end else if (req.lba[31:28] != 4'h0) begin
        res.addr_mode     = AM_LBA48;
        res.command       = (req.op == OP_WRITE) ? CMD_WR_EXT : CMD_RD_EXT;
        res.device_select = DEVSEL_LBA | {3'b000, slave, 4'h0};
        res.addr_byte0    = req.lba[7:0];
        res.addr_byte1    = req.lba[15:8];
        res.addr_byte2    = req.lba[23:16];
        res.addr_byte3    = req.lba[31:24];
      end else if (fl[FLG_LBA]) begin
        res.addr_mode     = AM_LBA28;
        res.command       = (req.op == OP_WRITE) ? CMD_WR : CMD_RD;
        res.device_select = DEVSEL_LBA | {3'b000, slave, req.lba[27:24]};
        res.addr_byte0    = req.lba[7:0];
        res.addr_byte1    = req.lba[15:8];
        res.addr_byte2    = req.lba[23:16];
      end else begin
        res.addr_mode     = AM_CHS;
        res.command       = (req.op == OP_WRITE) ? CMD_WR : CMD_RD;
        res.device_select = DEVSEL_CHS | {3'b000, slave, chs_head};
        res.addr_byte0    = {2'b00, chs_sect};
        res.addr_byte1    = chs_cyl[7:0];
        res.addr_byte2    = chs_cyl[15:8];
      end
    end
  end

endmodule
`default_nettype wire
